// File: sv/kmr_pkg.sv
// kmr_pkg: shared constants, types and square helpers for the killer move reorder block.
// No dependencies; used by kmr_cell, kmr_ring and killer_move_reorder_top.
package kmr_pkg;

    localparam int LIST_SIZE = 256;
    localparam int MAX_DEPTH = 128;

    localparam int POS_W   = (LIST_SIZE > 2) ? $clog2(LIST_SIZE) : 1;
    localparam int DADDR_W = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;

    localparam int WORD_W   = 32;
    localparam int SQ_W     = 6;
    localparam int FROM_LSB = 12;
    localparam int TO_LSB   = 18;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [POS_W:0]     t_end;
    typedef logic [DADDR_W-1:0] t_daddr;
    typedef logic [SQ_W-1:0]    t_sq;

    typedef enum logic [1:0] {
        ACT_SAVE    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_PROMOTE = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_FWD  = 2'd1,
        OP_BWD  = 2'd2,
        OP_LOAD = 2'd3
    } t_cell_op;

    // ring control from the sequencer
    typedef struct packed {
        logic  step_fwd;   // every cell takes its upper neighbor, head index + 1
        logic  step_bwd;   // every cell not loaded takes its lower neighbor, head index - 1
        logic  load0;      // cell 0 takes load_word
        logic  load1;      // cell 1 takes load_word
        t_word load_word;
    } t_ring_ctl;

    function automatic t_sq sq_from(input t_word w);
        return w[FROM_LSB +: SQ_W];
    endfunction

    function automatic t_sq sq_to(input t_word w);
        return w[TO_LSB +: SQ_W];
    endfunction

endpackage

// File: sv/kmr_cell.sv
// kmr_cell: one list entry of the move ring; holds, shifts from a neighbor or loads.
// Depends on kmr_pkg.
module kmr_cell (
    input  logic              i_clk,
    input  kmr_pkg::t_cell_op i_op,
    input  kmr_pkg::t_word    i_prev,
    input  kmr_pkg::t_word    i_next,
    input  kmr_pkg::t_word    i_load,
    output kmr_pkg::t_word    o_word
);

    kmr_pkg::t_word r_word;
    kmr_pkg::t_word n_word;

    always_comb begin
        case (i_op)
            kmr_pkg::OP_HOLD: n_word = r_word;
            kmr_pkg::OP_FWD:  n_word = i_next;
            kmr_pkg::OP_BWD:  n_word = i_prev;
            kmr_pkg::OP_LOAD: n_word = i_load;
            default:          n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: sv/kmr_ring.sv
// kmr_ring: circular row of kmr_cell entries holding the move list.
// Depends on kmr_pkg and kmr_cell. Cell 0 is the head, the last cell its lower neighbor.
module kmr_ring (
    input  logic               i_clk,
    input  kmr_pkg::t_ring_ctl i_ctl,
    output kmr_pkg::t_word     o_head,
    output kmr_pkg::t_word     o_tail
);

    localparam int N = kmr_pkg::LIST_SIZE;

    kmr_pkg::t_word words [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            kmr_pkg::t_cell_op op;

            always_comb begin
                if ((k == 0 && i_ctl.load0) || (k == 1 && i_ctl.load1)) begin
                    op = kmr_pkg::OP_LOAD;
                end else if (i_ctl.step_fwd) begin
                    op = kmr_pkg::OP_FWD;
                end else if (i_ctl.step_bwd) begin
                    op = kmr_pkg::OP_BWD;
                end else begin
                    op = kmr_pkg::OP_HOLD;
                end
            end

            kmr_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (op),
                .i_prev (words[(k + N - 1) % N]),
                .i_next (words[(k + 1) % N]),
                .i_load (i_ctl.load_word),
                .o_word (words[k])
            );
        end
    endgenerate

    assign o_head = words[0];
    assign o_tail = words[N-1];

endmodule

// File: sv/killer_move_reorder_top.sv
// killer_move_reorder_top: move list ring, killer table and the sequencer that drives them.
// Depends on kmr_pkg, kmr_ring (and through it kmr_cell).
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid / o_in_ready, i_action..i_move_word | into block
//  out     | o_out_valid / i_out_ready, o_found..o_read_word | out of block
//
// One item at a time. The list sits in a ring of cells that turns one entry per cycle;
// save, write and read turn it to the index, and promote turns it to start, scans, then
// shifts back to start.
// Reset clears the killer table through per-depth valid bits; no clearing pass.
// A stalled output holds the finished item; the next item is taken once the block is idle.
module killer_move_reorder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [6:0]  i_depth,
    input  logic [7:0]  i_index,
    input  logic [7:0]  i_start_req,
    input  logic [8:0]  i_list_end,
    input  logic [31:0] i_move_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [7:0]  o_found_index,
    output logic [31:0] o_read_word
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SEEK = 6'b000010,
        S_EXEC = 6'b000100,
        S_SCAN = 6'b001000,
        S_BACK = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    kmr_pkg::t_action r_act;
    kmr_pkg::t_pos    r_pos;
    kmr_pkg::t_pos    n_pos;
    kmr_pkg::t_pos    r_target;
    kmr_pkg::t_pos    r_hit;
    kmr_pkg::t_end    r_end;
    kmr_pkg::t_daddr  r_daddr;
    kmr_pkg::t_word   r_word;
    kmr_pkg::t_word   r_carry;
    logic             r_tvalid;
    logic             r_run;

    logic             r_res_found;
    logic [7:0]       r_res_idx;
    kmr_pkg::t_word   r_res_word;

    logic             r_out_valid;
    logic             r_out_found;
    logic [7:0]       r_out_idx;
    kmr_pkg::t_word   r_out_word;

    // killer table
    logic [2*kmr_pkg::SQ_W-1:0] r_kmem [kmr_pkg::MAX_DEPTH];
    logic [kmr_pkg::MAX_DEPTH-1:0] r_kvalid;
    logic [2*kmr_pkg::SQ_W-1:0] r_kq;
    logic             r_kq_valid;
    logic             kill_we;
    kmr_pkg::t_sq     kill_from;
    kmr_pkg::t_sq     kill_to;

    kmr_pkg::t_ring_ctl ctl;
    kmr_pkg::t_word   head;
    kmr_pkg::t_word   tail;

    logic             accept;
    logic             out_free;
    logic             head_match;
    logic             scan_more;
    kmr_pkg::t_action in_act;
    kmr_pkg::t_end    in_end;
    kmr_pkg::t_daddr  in_daddr;

    kmr_ring u_ring (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .o_head (head),
        .o_tail (tail)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_act     = kmr_pkg::t_action'(i_action);
    assign in_daddr   = kmr_pkg::t_daddr'(i_depth);
    assign in_end     = (int'(i_list_end) > kmr_pkg::LIST_SIZE)
                      ? kmr_pkg::t_end'(kmr_pkg::LIST_SIZE)
                      : kmr_pkg::t_end'(i_list_end);

    assign kill_from  = r_kq_valid ? r_kq[2*kmr_pkg::SQ_W-1:kmr_pkg::SQ_W] : '0;
    assign kill_to    = r_kq_valid ? r_kq[kmr_pkg::SQ_W-1:0] : '0;
    assign head_match = (kmr_pkg::sq_from(head) == kill_from)
                     && (kmr_pkg::sq_to(head) == kill_to);
    assign scan_more  = (int'(r_pos) + 1) < int'(r_end);
    assign kill_we    = (r_state == S_EXEC) && (r_act == kmr_pkg::ACT_SAVE)
                     && r_run && r_tvalid;

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        ctl            = '0;
        ctl.load_word  = r_word;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                if (r_act == kmr_pkg::ACT_PROMOTE && !r_run) begin
                    n_state = S_DONE;
                end else if (!r_tvalid || r_pos == r_target) begin
                    n_state = (r_act == kmr_pkg::ACT_PROMOTE) ? S_SCAN : S_EXEC;
                end else if (r_pos < r_target) begin
                    ctl.step_fwd = 1'b1;
                    n_pos        = r_pos + kmr_pkg::t_pos'(1);
                end else begin
                    ctl.step_bwd = 1'b1;
                    n_pos        = r_pos - kmr_pkg::t_pos'(1);
                end
            end
            S_EXEC: begin
                ctl.load0 = (r_act == kmr_pkg::ACT_WRITE) && r_tvalid;
                n_state   = S_DONE;
            end
            S_SCAN: begin
                if (head_match) begin
                    n_state = S_BACK;
                end else if (scan_more) begin
                    ctl.step_fwd = 1'b1;
                    n_pos        = r_pos + kmr_pkg::t_pos'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BACK: begin
                if (r_pos == r_target) begin
                    // hit lands at start
                    ctl.load0     = 1'b1;
                    ctl.load_word = r_carry;
                    n_state       = S_DONE;
                end else begin
                    // entry j takes j-1 while the ring turns back by one
                    ctl.step_bwd  = 1'b1;
                    ctl.load1     = 1'b1;
                    ctl.load_word = tail;
                    n_pos         = r_pos - kmr_pkg::t_pos'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_kvalid    <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (kill_we) begin
                r_kvalid[r_daddr] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (kill_we) begin
            r_kmem[r_daddr] <= {kmr_pkg::sq_from(head), kmr_pkg::sq_to(head)};
        end
        if (accept) begin
            r_kq       <= r_kmem[in_daddr];
            r_kq_valid <= r_kvalid[in_daddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act       <= in_act;
            r_daddr     <= in_daddr;
            r_word      <= i_move_word;
            r_end       <= in_end;
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
            r_res_word  <= '0;
            if (in_act == kmr_pkg::ACT_PROMOTE) begin
                r_target <= kmr_pkg::t_pos'(i_start_req);
                r_tvalid <= 1'b1;
                r_run    <= (int'(i_depth) < kmr_pkg::MAX_DEPTH)
                         && (int'(i_start_req) < int'(in_end));
            end else begin
                r_target <= kmr_pkg::t_pos'(i_index);
                r_tvalid <= int'(i_index) < kmr_pkg::LIST_SIZE;
                r_run    <= int'(i_depth) < kmr_pkg::MAX_DEPTH;
            end
        end
        if (r_state == S_EXEC && r_act == kmr_pkg::ACT_READ && r_tvalid) begin
            r_res_word <= head;
        end
        if (r_state == S_SCAN && head_match) begin
            r_carry <= head;
            r_hit   <= r_pos;
        end
        if (r_state == S_BACK && r_pos == r_target) begin
            r_res_found <= 1'b1;
            r_res_idx   <= 8'(r_hit);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
            r_out_word  <= r_res_word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_found_index = r_out_idx;
    assign o_read_word   = r_out_word;

    a_ring_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.step_fwd && ctl.step_bwd))
        else $error("ring stepped both ways");

    a_scan_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (int'(r_pos) < int'(r_end)))
        else $error("scan beyond list end");

    a_back_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BACK) |-> (r_pos >= r_target && r_hit >= r_pos))
        else $error("shift-back outside start..hit");

    a_found_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_read_word == '0))
        else $error("promote result carries a read word");

endmodule

// File: dv/tb_killer_move_reorder_top.sv
// Self-checking testbench for killer_move_reorder_top: directed and random save, write,
// promote and read items, checked against an in-bench model of the list and killer table.
// Depends on kmr_pkg and the killer_move_reorder_top RTL.
module tb_killer_move_reorder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        kmr_pkg::t_action action;
        logic [6:0]       depth;
        logic [7:0]       index;
        logic [7:0]       start;
        logic [8:0]       list_end;
        kmr_pkg::t_word   word;
    } t_move_req;

    typedef struct packed {
        logic           found;
        logic [7:0]     found_index;
        kmr_pkg::t_word read_word;
    } t_move_outcome;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_ready = 1'b0;
    t_move_req   drive_req = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_found;
    logic [7:0]  o_found_index;
    logic [31:0] o_read_word;

    // bench copy of the block state
    kmr_pkg::t_word             list_copy [kmr_pkg::LIST_SIZE];
    logic [2*kmr_pkg::SQ_W-1:0] killer_pair [kmr_pkg::MAX_DEPTH];
    // entries the stimulus has written so far
    logic [kmr_pkg::LIST_SIZE-1:0] gen_written = '0;

    t_move_req     actions_pending [$];
    t_move_outcome outcome_due [$];

    int n_generated = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_hits = 0;
    int n_by_action [4] = '{default: 0};
    int idle_cycles = 0;

    killer_move_reorder_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (drive_req.action),
        .i_depth       (drive_req.depth),
        .i_index       (drive_req.index),
        .i_start_req   (drive_req.start),
        .i_list_end    (drive_req.list_end),
        .i_move_word   (drive_req.word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_read_word   (o_read_word)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // to square above from square, both as one compare key
    function automatic logic [2*kmr_pkg::SQ_W-1:0] squares_of(input kmr_pkg::t_word w);
        return {w[kmr_pkg::TO_LSB +: kmr_pkg::SQ_W], w[kmr_pkg::FROM_LSB +: kmr_pkg::SQ_W]};
    endfunction

    function automatic t_move_outcome apply_move_action(input t_move_req rq);
        t_move_outcome  res;
        kmr_pkg::t_word hit_word;
        int             scan_end;
        int             j;
        res = '0;
        case (rq.action)
            kmr_pkg::ACT_SAVE: killer_pair[rq.depth] = squares_of(list_copy[rq.index]);
            kmr_pkg::ACT_WRITE: list_copy[rq.index] = rq.word;
            kmr_pkg::ACT_PROMOTE: begin
                scan_end = (int'(rq.list_end) > kmr_pkg::LIST_SIZE) ? kmr_pkg::LIST_SIZE
                                                                    : int'(rq.list_end);
                j = rq.start;
                while (j < scan_end && squares_of(list_copy[j]) != killer_pair[rq.depth])
                    j++;
                if (j < scan_end) begin
                    hit_word = list_copy[j];
                    for (int k = j; k > rq.start; k--)
                        list_copy[k] = list_copy[k-1];
                    list_copy[rq.start] = hit_word;
                    res.found = 1'b1;
                    res.found_index = j[7:0];
                end
            end
            default: res.read_word = list_copy[rq.index];
        endcase
        return res;
    endfunction

    function automatic kmr_pkg::t_word move_with(input int from_sq, input int to_sq,
                                                 input kmr_pkg::t_word filler);
        kmr_pkg::t_word w;
        w = filler;
        w[kmr_pkg::FROM_LSB +: kmr_pkg::SQ_W] = from_sq[kmr_pkg::SQ_W-1:0];
        w[kmr_pkg::TO_LSB +: kmr_pkg::SQ_W] = to_sq[kmr_pkg::SQ_W-1:0];
        return w;
    endfunction

    // squares mostly from a small pool so that killers hit often
    function automatic kmr_pkg::t_word random_move();
        if ($urandom_range(0, 9) < 7)
            return move_with($urandom_range(0, 3), $urandom_range(0, 3), $urandom);
        return $urandom;
    endfunction

    function automatic int pick_written();
        int k;
        do
            k = $urandom_range(0, kmr_pkg::LIST_SIZE - 1);
        while (!gen_written[k]);
        return k;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // a negative field means the block ignores it: fill with noise
    task automatic queue_op(input kmr_pkg::t_action act, input int depth, input int index,
                            input int start, input int lend, input kmr_pkg::t_word word);
        t_move_req rq;
        rq.action   = act;
        rq.depth    = (depth < 0) ? 7'($urandom_range(0, 127)) : depth[6:0];
        rq.index    = (index < 0) ? 8'($urandom_range(0, 255)) : index[7:0];
        rq.start    = (start < 0) ? 8'($urandom_range(0, 255)) : start[7:0];
        rq.list_end = (lend < 0) ? 9'($urandom_range(0, 511)) : lend[8:0];
        rq.word     = word;
        actions_pending.push_back(rq);
        if (act == kmr_pkg::ACT_WRITE)
            gen_written[rq.index] = 1'b1;
        n_generated++;
    endtask

    // sender
    always @(posedge clk) begin : drive_proc
        logic          next_valid;
        t_move_req     next_req;
        t_move_outcome predicted;
        int            send_gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = in_valid;
            next_req = drive_req;
            if (in_valid && o_in_ready) begin
                predicted = apply_move_action(drive_req);
                outcome_due.push_back(predicted);
                n_accepted++;
                n_by_action[drive_req.action]++;
                if (predicted.found)
                    n_hits++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (actions_pending.size() != 0) begin
                    next_req = actions_pending.pop_front();
                    next_valid = 1'b1;
                    send_gap = ((n_accepted / 100) % 4 == 1) ? 0 : pick_gap();
                end
            end
            in_valid <= next_valid;
            drive_req <= next_req;
        end
    end

    // receiver, with one long hold-off once results are flowing
    always @(posedge clk) begin : ready_proc
        logic next_ready;
        int   ready_gap;
        int   hold_left;
        int   n_taken;
        logic hold_done;
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_gap = 0;
            hold_left = 0;
            n_taken = 0;
            hold_done = 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_taken++;
                ready_gap = ((n_taken / 100) % 4 == 2) ? 0 : pick_gap();
            end
            if (!hold_done && n_taken >= 200) begin
                hold_left = PRESSURE_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            out_ready <= next_ready;
        end
    end

    // result checker
    always @(posedge clk) begin : check_proc
        t_move_outcome want;
        if (rst_n && o_out_valid && out_ready) begin
            n_checked++;
            if (outcome_due.size() == 0) begin
                $error("result with no item outstanding");
                n_errors++;
            end else begin
                want = outcome_due.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    n_errors++;
                end
                if (o_found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, o_found_index);
                    n_errors++;
                end
                if (o_read_word !== want.read_word) begin
                    $error("read_word: expected %08h, got %08h", want.read_word, o_read_word);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int lo;
        int hi;
        int span;
        int d;
        int src;
        int lend;
        int r;
        for (int k = 0; k < kmr_pkg::LIST_SIZE; k++)
            list_copy[k] = '0;
        for (int k = 0; k < kmr_pkg::MAX_DEPTH; k++)
            killer_pair[k] = '0;

        // directed: corner words, hit at start, rotation, saturated bound, empty ranges
        queue_op(kmr_pkg::ACT_WRITE, -1, 0, -1, -1, '0);
        queue_op(kmr_pkg::ACT_WRITE, -1, 255, -1, -1, '1);
        queue_op(kmr_pkg::ACT_WRITE, -1, 1, -1, -1, move_with(5, 9, 32'h0000_0000));
        queue_op(kmr_pkg::ACT_WRITE, -1, 2, -1, -1, move_with(5, 9, 32'h5555_5555));
        queue_op(kmr_pkg::ACT_READ, -1, 0, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_READ, -1, 255, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_READ, -1, 1, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_PROMOTE, 50, -1, 0, 1, $urandom);  // killer still clear, matches the zero word at 0
        queue_op(kmr_pkg::ACT_PROMOTE, 50, -1, 1, 3, $urandom);  // full scan, no hit
        queue_op(kmr_pkg::ACT_SAVE, 127, 2, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_PROMOTE, 127, -1, 0, 3, $urandom); // hit at 1, rotates 0..1
        queue_op(kmr_pkg::ACT_READ, -1, 0, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_READ, -1, 1, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_SAVE, 0, 255, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_PROMOTE, 0, -1, 255, 511, $urandom); // bound clipped to list size
        queue_op(kmr_pkg::ACT_PROMOTE, 0, -1, 200, 100, $urandom);
        queue_op(kmr_pkg::ACT_PROMOTE, 0, -1, 255, 255, $urandom);
        queue_op(kmr_pkg::ACT_PROMOTE, 127, -1, 3, 3, $urandom);
        queue_op(kmr_pkg::ACT_WRITE, -1, 128, -1, -1, 32'hA5C3_3C5A);
        queue_op(kmr_pkg::ACT_READ, -1, 128, -1, -1, $urandom);
        queue_op(kmr_pkg::ACT_SAVE, 64, 0, -1, -1, $urandom);

        // random: mostly fill-save-promote sequences over fully written windows
        while (n_generated < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // wide windows only while there is room left in the item budget
                span = ($urandom_range(0, 19) == 0 && n_generated < RANDOM_ITEMS - 300)
                     ? $urandom_range(13, kmr_pkg::LIST_SIZE)
                     : $urandom_range(1, 12);
                lo = $urandom_range(0, kmr_pkg::LIST_SIZE - span);
                hi = lo + span;
                for (int k = lo; k < hi; k++)
                    if (!gen_written[k] || $urandom_range(0, 2) == 0)
                        queue_op(kmr_pkg::ACT_WRITE, -1, k, -1, -1, random_move());
                d = $urandom_range(0, kmr_pkg::MAX_DEPTH - 1);
                src = ($urandom_range(0, 3) == 0) ? pick_written() : $urandom_range(lo, hi - 1);
                queue_op(kmr_pkg::ACT_SAVE, d, src, -1, -1, $urandom);
                lend = hi;
                if (hi == kmr_pkg::LIST_SIZE && $urandom_range(0, 1) == 1)
                    lend = $urandom_range(kmr_pkg::LIST_SIZE, 511);
                queue_op(kmr_pkg::ACT_PROMOTE, d, -1, lo, lend, $urandom);
                if ($urandom_range(0, 2) == 0)
                    queue_op(kmr_pkg::ACT_PROMOTE, d, -1, lo, lend, $urandom);
                repeat ($urandom_range(0, 2))
                    queue_op(kmr_pkg::ACT_READ, -1, $urandom_range(lo, hi - 1), -1, -1,
                             $urandom);
            end else if (r < 72) begin
                queue_op(kmr_pkg::ACT_WRITE, -1, -1, -1, -1, $urandom);
            end else if (r < 82) begin
                queue_op(kmr_pkg::ACT_READ, -1, pick_written(), -1, -1, $urandom);
            end else if (r < 89) begin
                lo = $urandom_range(0, 255);
                queue_op(kmr_pkg::ACT_PROMOTE, -1, -1, lo, $urandom_range(0, lo), $urandom);
            end else if (r < 94) begin
                queue_op(kmr_pkg::ACT_SAVE, -1, pick_written(), -1, -1, $urandom);
            end else begin
                // stale killer over whatever written run starts here
                lo = pick_written();
                hi = lo + 1;
                span = $urandom_range(1, 40);
                while (hi < kmr_pkg::LIST_SIZE && gen_written[hi] && hi - lo < span)
                    hi++;
                lend = hi;
                if (hi == kmr_pkg::LIST_SIZE && $urandom_range(0, 1) == 1)
                    lend = $urandom_range(kmr_pkg::LIST_SIZE, 511);
                queue_op(kmr_pkg::ACT_PROMOTE, -1, -1, lo, lend, $urandom);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_generated)
            @(posedge clk);
        while (outcome_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d save, %0d write, %0d promote (%0d hits), %0d read",
                 n_accepted, n_by_action[kmr_pkg::ACT_SAVE], n_by_action[kmr_pkg::ACT_WRITE],
                 n_by_action[kmr_pkg::ACT_PROMOTE], n_hits, n_by_action[kmr_pkg::ACT_READ]);
        $display("%0d results compared, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
